// ===== rtl/bf_pkg.sv =====
// Shared types, codes and initial pi-derived tables for the Blowfish engine.
package bf_pkg;

	localparam int ROUNDS        = 16;
	localparam int SUBKEYS       = ROUNDS + 2;
	localparam int NUM_SBOX      = 4;
	localparam int SBOX_DEPTH    = 256;
	localparam int KEY_WORDS     = 7;
	localparam int MAX_KEY_BYTES = 56;
	localparam int SCHED_BLOCKS  = SUBKEYS / 2 + (NUM_SBOX * SBOX_DEPTH) / 2;

	typedef enum logic [1:0] {
		OP_ENC    = 2'd0,
		OP_DEC    = 2'd1,
		OP_EXPAND = 2'd2,
		OP_NOP    = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		STAT_OK        = 2'd0,
		STAT_NOT_KEYED = 2'd1,
		STAT_WEAK      = 2'd2
	} status_t;

	localparam logic [2:0] CFG_KEY_BYTES = 3'd7;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_INIT,
		ST_CSTART,
		ST_CRUN,
		ST_WRR,
		ST_CKLD,
		ST_CKSCAN,
		ST_CKLAST
	} fsm_t;

	localparam logic [31:0] PI_P [SUBKEYS] = '{
		32'h243f6a88, 32'h85a308d3, 32'h13198a2e, 32'h03707344, 32'ha4093822, 32'h299f31d0,
		32'h082efa98, 32'hec4e6c89, 32'h452821e6, 32'h38d01377, 32'hbe5466cf, 32'h34e90c6c,
		32'hc0ac29b7, 32'hc97c50dd, 32'h3f84d5b5, 32'hb5470917, 32'h9216d5d9, 32'h8979fb1b
	};

	localparam logic [31:0] PI_S [NUM_SBOX][SBOX_DEPTH] = '{
		'{
		32'hd1310ba6, 32'h98dfb5ac, 32'h2ffd72db, 32'hd01adfb7, 32'hb8e1afed, 32'h6a267e96,
		32'hba7c9045, 32'hf12c7f99, 32'h24a19947, 32'hb3916cf7, 32'h0801f2e2, 32'h858efc16,
		32'h636920d8, 32'h71574e69, 32'ha458fea3, 32'hf4933d7e, 32'h0d95748f, 32'h728eb658,
		32'h718bcd58, 32'h82154aee, 32'h7b54a41d, 32'hc25a59b5, 32'h9c30d539, 32'h2af26013,
		32'hc5d1b023, 32'h286085f0, 32'hca417918, 32'hb8db38ef, 32'h8e79dcb0, 32'h603a180e,
		32'h6c9e0e8b, 32'hb01e8a3e, 32'hd71577c1, 32'hbd314b27, 32'h78af2fda, 32'h55605c60,
		32'he65525f3, 32'haa55ab94, 32'h57489862, 32'h63e81440, 32'h55ca396a, 32'h2aab10b6,
		32'hb4cc5c34, 32'h1141e8ce, 32'ha15486af, 32'h7c72e993, 32'hb3ee1411, 32'h636fbc2a,
		32'h2ba9c55d, 32'h741831f6, 32'hce5c3e16, 32'h9b87931e, 32'hafd6ba33, 32'h6c24cf5c,
		32'h7a325381, 32'h28958677, 32'h3b8f4898, 32'h6b4bb9af, 32'hc4bfe81b, 32'h66282193,
		32'h61d809cc, 32'hfb21a991, 32'h487cac60, 32'h5dec8032, 32'hef845d5d, 32'he98575b1,
		32'hdc262302, 32'heb651b88, 32'h23893e81, 32'hd396acc5, 32'h0f6d6ff3, 32'h83f44239,
		32'h2e0b4482, 32'ha4842004, 32'h69c8f04a, 32'h9e1f9b5e, 32'h21c66842, 32'hf6e96c9a,
		32'h670c9c61, 32'habd388f0, 32'h6a51a0d2, 32'hd8542f68, 32'h960fa728, 32'hab5133a3,
		32'h6eef0b6c, 32'h137a3be4, 32'hba3bf050, 32'h7efb2a98, 32'ha1f1651d, 32'h39af0176,
		32'h66ca593e, 32'h82430e88, 32'h8cee8619, 32'h456f9fb4, 32'h7d84a5c3, 32'h3b8b5ebe,
		32'he06f75d8, 32'h85c12073, 32'h401a449f, 32'h56c16aa6, 32'h4ed3aa62, 32'h363f7706,
		32'h1bfedf72, 32'h429b023d, 32'h37d0d724, 32'hd00a1248, 32'hdb0fead3, 32'h49f1c09b,
		32'h075372c9, 32'h80991b7b, 32'h25d479d8, 32'hf6e8def7, 32'he3fe501a, 32'hb6794c3b,
		32'h976ce0bd, 32'h04c006ba, 32'hc1a94fb6, 32'h409f60c4, 32'h5e5c9ec2, 32'h196a2463,
		32'h68fb6faf, 32'h3e6c53b5, 32'h1339b2eb, 32'h3b52ec6f, 32'h6dfc511f, 32'h9b30952c,
		32'hcc814544, 32'haf5ebd09, 32'hbee3d004, 32'hde334afd, 32'h660f2807, 32'h192e4bb3,
		32'hc0cba857, 32'h45c8740f, 32'hd20b5f39, 32'hb9d3fbdb, 32'h5579c0bd, 32'h1a60320a,
		32'hd6a100c6, 32'h402c7279, 32'h679f25fe, 32'hfb1fa3cc, 32'h8ea5e9f8, 32'hdb3222f8,
		32'h3c7516df, 32'hfd616b15, 32'h2f501ec8, 32'had0552ab, 32'h323db5fa, 32'hfd238760,
		32'h53317b48, 32'h3e00df82, 32'h9e5c57bb, 32'hca6f8ca0, 32'h1a87562e, 32'hdf1769db,
		32'hd542a8f6, 32'h287effc3, 32'hac6732c6, 32'h8c4f5573, 32'h695b27b0, 32'hbbca58c8,
		32'he1ffa35d, 32'hb8f011a0, 32'h10fa3d98, 32'hfd2183b8, 32'h4afcb56c, 32'h2dd1d35b,
		32'h9a53e479, 32'hb6f84565, 32'hd28e49bc, 32'h4bfb9790, 32'he1ddf2da, 32'ha4cb7e33,
		32'h62fb1341, 32'hcee4c6e8, 32'hef20cada, 32'h36774c01, 32'hd07e9efe, 32'h2bf11fb4,
		32'h95dbda4d, 32'hae909198, 32'heaad8e71, 32'h6b93d5a0, 32'hd08ed1d0, 32'hafc725e0,
		32'h8e3c5b2f, 32'h8e7594b7, 32'h8ff6e2fb, 32'hf2122b64, 32'h8888b812, 32'h900df01c,
		32'h4fad5ea0, 32'h688fc31c, 32'hd1cff191, 32'hb3a8c1ad, 32'h2f2f2218, 32'hbe0e1777,
		32'hea752dfe, 32'h8b021fa1, 32'he5a0cc0f, 32'hb56f74e8, 32'h18acf3d6, 32'hce89e299,
		32'hb4a84fe0, 32'hfd13e0b7, 32'h7cc43b81, 32'hd2ada8d9, 32'h165fa266, 32'h80957705,
		32'h93cc7314, 32'h211a1477, 32'he6ad2065, 32'h77b5fa86, 32'hc75442f5, 32'hfb9d35cf,
		32'hebcdaf0c, 32'h7b3e89a0, 32'hd6411bd3, 32'hae1e7e49, 32'h00250e2d, 32'h2071b35e,
		32'h226800bb, 32'h57b8e0af, 32'h2464369b, 32'hf009b91e, 32'h5563911d, 32'h59dfa6aa,
		32'h78c14389, 32'hd95a537f, 32'h207d5ba2, 32'h02e5b9c5, 32'h83260376, 32'h6295cfa9,
		32'h11c81968, 32'h4e734a41, 32'hb3472dca, 32'h7b14a94a, 32'h1b510052, 32'h9a532915,
		32'hd60f573f, 32'hbc9bc6e4, 32'h2b60a476, 32'h81e67400, 32'h08ba6fb5, 32'h571be91f,
		32'hf296ec6b, 32'h2a0dd915, 32'hb6636521, 32'he7b9f9b6, 32'hff34052e, 32'hc5855664,
		32'h53b02d5d, 32'ha99f8fa1, 32'h08ba4799, 32'h6e85076a
		},
		'{
		32'h4b7a70e9, 32'hb5b32944, 32'hdb75092e, 32'hc4192623, 32'had6ea6b0, 32'h49a7df7d,
		32'h9cee60b8, 32'h8fedb266, 32'hecaa8c71, 32'h699a17ff, 32'h5664526c, 32'hc2b19ee1,
		32'h193602a5, 32'h75094c29, 32'ha0591340, 32'he4183a3e, 32'h3f54989a, 32'h5b429d65,
		32'h6b8fe4d6, 32'h99f73fd6, 32'ha1d29c07, 32'hefe830f5, 32'h4d2d38e6, 32'hf0255dc1,
		32'h4cdd2086, 32'h8470eb26, 32'h6382e9c6, 32'h021ecc5e, 32'h09686b3f, 32'h3ebaefc9,
		32'h3c971814, 32'h6b6a70a1, 32'h687f3584, 32'h52a0e286, 32'hb79c5305, 32'haa500737,
		32'h3e07841c, 32'h7fdeae5c, 32'h8e7d44ec, 32'h5716f2b8, 32'hb03ada37, 32'hf0500c0d,
		32'hf01c1f04, 32'h0200b3ff, 32'hae0cf51a, 32'h3cb574b2, 32'h25837a58, 32'hdc0921bd,
		32'hd19113f9, 32'h7ca92ff6, 32'h94324773, 32'h22f54701, 32'h3ae5e581, 32'h37c2dadc,
		32'hc8b57634, 32'h9af3dda7, 32'ha9446146, 32'h0fd0030e, 32'hecc8c73e, 32'ha4751e41,
		32'he238cd99, 32'h3bea0e2f, 32'h3280bba1, 32'h183eb331, 32'h4e548b38, 32'h4f6db908,
		32'h6f420d03, 32'hf60a04bf, 32'h2cb81290, 32'h24977c79, 32'h5679b072, 32'hbcaf89af,
		32'hde9a771f, 32'hd9930810, 32'hb38bae12, 32'hdccf3f2e, 32'h5512721f, 32'h2e6b7124,
		32'h501adde6, 32'h9f84cd87, 32'h7a584718, 32'h7408da17, 32'hbc9f9abc, 32'he94b7d8c,
		32'hec7aec3a, 32'hdb851dfa, 32'h63094366, 32'hc464c3d2, 32'hef1c1847, 32'h3215d908,
		32'hdd433b37, 32'h24c2ba16, 32'h12a14d43, 32'h2a65c451, 32'h50940002, 32'h133ae4dd,
		32'h71dff89e, 32'h10314e55, 32'h81ac77d6, 32'h5f11199b, 32'h043556f1, 32'hd7a3c76b,
		32'h3c11183b, 32'h5924a509, 32'hf28fe6ed, 32'h97f1fbfa, 32'h9ebabf2c, 32'h1e153c6e,
		32'h86e34570, 32'heae96fb1, 32'h860e5e0a, 32'h5a3e2ab3, 32'h771fe71c, 32'h4e3d06fa,
		32'h2965dcb9, 32'h99e71d0f, 32'h803e89d6, 32'h5266c825, 32'h2e4cc978, 32'h9c10b36a,
		32'hc6150eba, 32'h94e2ea78, 32'ha5fc3c53, 32'h1e0a2df4, 32'hf2f74ea7, 32'h361d2b3d,
		32'h1939260f, 32'h19c27960, 32'h5223a708, 32'hf71312b6, 32'hebadfe6e, 32'heac31f66,
		32'he3bc4595, 32'ha67bc883, 32'hb17f37d1, 32'h018cff28, 32'hc332ddef, 32'hbe6c5aa5,
		32'h65582185, 32'h68ab9802, 32'heecea50f, 32'hdb2f953b, 32'h2aef7dad, 32'h5b6e2f84,
		32'h1521b628, 32'h29076170, 32'hecdd4775, 32'h619f1510, 32'h13cca830, 32'heb61bd96,
		32'h0334fe1e, 32'haa0363cf, 32'hb5735c90, 32'h4c70a239, 32'hd59e9e0b, 32'hcbaade14,
		32'heecc86bc, 32'h60622ca7, 32'h9cab5cab, 32'hb2f3846e, 32'h648b1eaf, 32'h19bdf0ca,
		32'ha02369b9, 32'h655abb50, 32'h40685a32, 32'h3c2ab4b3, 32'h319ee9d5, 32'hc021b8f7,
		32'h9b540b19, 32'h875fa099, 32'h95f7997e, 32'h623d7da8, 32'hf837889a, 32'h97e32d77,
		32'h11ed935f, 32'h16681281, 32'h0e358829, 32'hc7e61fd6, 32'h96dedfa1, 32'h7858ba99,
		32'h57f584a5, 32'h1b227263, 32'h9b83c3ff, 32'h1ac24696, 32'hcdb30aeb, 32'h532e3054,
		32'h8fd948e4, 32'h6dbc3128, 32'h58ebf2ef, 32'h34c6ffea, 32'hfe28ed61, 32'hee7c3c73,
		32'h5d4a14d9, 32'he864b7e3, 32'h42105d14, 32'h203e13e0, 32'h45eee2b6, 32'ha3aaabea,
		32'hdb6c4f15, 32'hfacb4fd0, 32'hc742f442, 32'hef6abbb5, 32'h654f3b1d, 32'h41cd2105,
		32'hd81e799e, 32'h86854dc7, 32'he44b476a, 32'h3d816250, 32'hcf62a1f2, 32'h5b8d2646,
		32'hfc8883a0, 32'hc1c7b6a3, 32'h7f1524c3, 32'h69cb7492, 32'h47848a0b, 32'h5692b285,
		32'h095bbf00, 32'had19489d, 32'h1462b174, 32'h23820e00, 32'h58428d2a, 32'h0c55f5ea,
		32'h1dadf43e, 32'h233f7061, 32'h3372f092, 32'h8d937e41, 32'hd65fecf1, 32'h6c223bdb,
		32'h7cde3759, 32'hcbee7460, 32'h4085f2a7, 32'hce77326e, 32'ha6078084, 32'h19f8509e,
		32'he8efd855, 32'h61d99735, 32'ha969a7aa, 32'hc50c06c2, 32'h5a04abfc, 32'h800bcadc,
		32'h9e447a2e, 32'hc3453484, 32'hfdd56705, 32'h0e1e9ec9, 32'hdb73dbd3, 32'h105588cd,
		32'h675fda79, 32'he3674340, 32'hc5c43465, 32'h713e38d8, 32'h3d28f89e, 32'hf16dff20,
		32'h153e21e7, 32'h8fb03d4a, 32'he6e39f2b, 32'hdb83adf7
		},
		'{
		32'he93d5a68, 32'h948140f7, 32'hf64c261c, 32'h94692934, 32'h411520f7, 32'h7602d4f7,
		32'hbcf46b2e, 32'hd4a20068, 32'hd4082471, 32'h3320f46a, 32'h43b7d4b7, 32'h500061af,
		32'h1e39f62e, 32'h97244546, 32'h14214f74, 32'hbf8b8840, 32'h4d95fc1d, 32'h96b591af,
		32'h70f4ddd3, 32'h66a02f45, 32'hbfbc09ec, 32'h03bd9785, 32'h7fac6dd0, 32'h31cb8504,
		32'h96eb27b3, 32'h55fd3941, 32'hda2547e6, 32'habca0a9a, 32'h28507825, 32'h530429f4,
		32'h0a2c86da, 32'he9b66dfb, 32'h68dc1462, 32'hd7486900, 32'h680ec0a4, 32'h27a18dee,
		32'h4f3ffea2, 32'he887ad8c, 32'hb58ce006, 32'h7af4d6b6, 32'haace1e7c, 32'hd3375fec,
		32'hce78a399, 32'h406b2a42, 32'h20fe9e35, 32'hd9f385b9, 32'hee39d7ab, 32'h3b124e8b,
		32'h1dc9faf7, 32'h4b6d1856, 32'h26a36631, 32'heae397b2, 32'h3a6efa74, 32'hdd5b4332,
		32'h6841e7f7, 32'hca7820fb, 32'hfb0af54e, 32'hd8feb397, 32'h454056ac, 32'hba489527,
		32'h55533a3a, 32'h20838d87, 32'hfe6ba9b7, 32'hd096954b, 32'h55a867bc, 32'ha1159a58,
		32'hcca92963, 32'h99e1db33, 32'ha62a4a56, 32'h3f3125f9, 32'h5ef47e1c, 32'h9029317c,
		32'hfdf8e802, 32'h04272f70, 32'h80bb155c, 32'h05282ce3, 32'h95c11548, 32'he4c66d22,
		32'h48c1133f, 32'hc70f86dc, 32'h07f9c9ee, 32'h41041f0f, 32'h404779a4, 32'h5d886e17,
		32'h325f51eb, 32'hd59bc0d1, 32'hf2bcc18f, 32'h41113564, 32'h257b7834, 32'h602a9c60,
		32'hdff8e8a3, 32'h1f636c1b, 32'h0e12b4c2, 32'h02e1329e, 32'haf664fd1, 32'hcad18115,
		32'h6b2395e0, 32'h333e92e1, 32'h3b240b62, 32'heebeb922, 32'h85b2a20e, 32'he6ba0d99,
		32'hde720c8c, 32'h2da2f728, 32'hd0127845, 32'h95b794fd, 32'h647d0862, 32'he7ccf5f0,
		32'h5449a36f, 32'h877d48fa, 32'hc39dfd27, 32'hf33e8d1e, 32'h0a476341, 32'h992eff74,
		32'h3a6f6eab, 32'hf4f8fd37, 32'ha812dc60, 32'ha1ebddf8, 32'h991be14c, 32'hdb6e6b0d,
		32'hc67b5510, 32'h6d672c37, 32'h2765d43b, 32'hdcd0e804, 32'hf1290dc7, 32'hcc00ffa3,
		32'hb5390f92, 32'h690fed0b, 32'h667b9ffb, 32'hcedb7d9c, 32'ha091cf0b, 32'hd9155ea3,
		32'hbb132f88, 32'h515bad24, 32'h7b9479bf, 32'h763bd6eb, 32'h37392eb3, 32'hcc115979,
		32'h8026e297, 32'hf42e312d, 32'h6842ada7, 32'hc66a2b3b, 32'h12754ccc, 32'h782ef11c,
		32'h6a124237, 32'hb79251e7, 32'h06a1bbe6, 32'h4bfb6350, 32'h1a6b1018, 32'h11caedfa,
		32'h3d25bdd8, 32'he2e1c3c9, 32'h44421659, 32'h0a121386, 32'hd90cec6e, 32'hd5abea2a,
		32'h64af674e, 32'hda86a85f, 32'hbebfe988, 32'h64e4c3fe, 32'h9dbc8057, 32'hf0f7c086,
		32'h60787bf8, 32'h6003604d, 32'hd1fd8346, 32'hf6381fb0, 32'h7745ae04, 32'hd736fccc,
		32'h83426b33, 32'hf01eab71, 32'hb0804187, 32'h3c005e5f, 32'h77a057be, 32'hbde8ae24,
		32'h55464299, 32'hbf582e61, 32'h4e58f48f, 32'hf2ddfda2, 32'hf474ef38, 32'h8789bdc2,
		32'h5366f9c3, 32'hc8b38e74, 32'hb475f255, 32'h46fcd9b9, 32'h7aeb2661, 32'h8b1ddf84,
		32'h846a0e79, 32'h915f95e2, 32'h466e598e, 32'h20b45770, 32'h8cd55591, 32'hc902de4c,
		32'hb90bace1, 32'hbb8205d0, 32'h11a86248, 32'h7574a99e, 32'hb77f19b6, 32'he0a9dc09,
		32'h662d09a1, 32'hc4324633, 32'he85a1f02, 32'h09f0be8c, 32'h4a99a025, 32'h1d6efe10,
		32'h1ab93d1d, 32'h0ba5a4df, 32'ha186f20f, 32'h2868f169, 32'hdcb7da83, 32'h573906fe,
		32'ha1e2ce9b, 32'h4fcd7f52, 32'h50115e01, 32'ha70683fa, 32'ha002b5c4, 32'h0de6d027,
		32'h9af88c27, 32'h773f8641, 32'hc3604c06, 32'h61a806b5, 32'hf0177a28, 32'hc0f586e0,
		32'h006058aa, 32'h30dc7d62, 32'h11e69ed7, 32'h2338ea63, 32'h53c2dd94, 32'hc2c21634,
		32'hbbcbee56, 32'h90bcb6de, 32'hebfc7da1, 32'hce591d76, 32'h6f05e409, 32'h4b7c0188,
		32'h39720a3d, 32'h7c927c24, 32'h86e3725f, 32'h724d9db9, 32'h1ac15bb4, 32'hd39eb8fc,
		32'hed545578, 32'h08fca5b5, 32'hd83d7cd3, 32'h4dad0fc4, 32'h1e50ef5e, 32'hb161e6f8,
		32'ha28514d9, 32'h6c51133c, 32'h6fd5c7e7, 32'h56e14ec4, 32'h362abfce, 32'hddc6c837,
		32'hd79a3234, 32'h92638212, 32'h670efa8e, 32'h406000e0
		},
		'{
		32'h3a39ce37, 32'hd3faf5cf, 32'habc27737, 32'h5ac52d1b, 32'h5cb0679e, 32'h4fa33742,
		32'hd3822740, 32'h99bc9bbe, 32'hd5118e9d, 32'hbf0f7315, 32'hd62d1c7e, 32'hc700c47b,
		32'hb78c1b6b, 32'h21a19045, 32'hb26eb1be, 32'h6a366eb4, 32'h5748ab2f, 32'hbc946e79,
		32'hc6a376d2, 32'h6549c2c8, 32'h530ff8ee, 32'h468dde7d, 32'hd5730a1d, 32'h4cd04dc6,
		32'h2939bbdb, 32'ha9ba4650, 32'hac9526e8, 32'hbe5ee304, 32'ha1fad5f0, 32'h6a2d519a,
		32'h63ef8ce2, 32'h9a86ee22, 32'hc089c2b8, 32'h43242ef6, 32'ha51e03aa, 32'h9cf2d0a4,
		32'h83c061ba, 32'h9be96a4d, 32'h8fe51550, 32'hba645bd6, 32'h2826a2f9, 32'ha73a3ae1,
		32'h4ba99586, 32'hef5562e9, 32'hc72fefd3, 32'hf752f7da, 32'h3f046f69, 32'h77fa0a59,
		32'h80e4a915, 32'h87b08601, 32'h9b09e6ad, 32'h3b3ee593, 32'he990fd5a, 32'h9e34d797,
		32'h2cf0b7d9, 32'h022b8b51, 32'h96d5ac3a, 32'h017da67d, 32'hd1cf3ed6, 32'h7c7d2d28,
		32'h1f9f25cf, 32'hadf2b89b, 32'h5ad6b472, 32'h5a88f54c, 32'he029ac71, 32'he019a5e6,
		32'h47b0acfd, 32'hed93fa9b, 32'he8d3c48d, 32'h283b57cc, 32'hf8d56629, 32'h79132e28,
		32'h785f0191, 32'hed756055, 32'hf7960e44, 32'he3d35e8c, 32'h15056dd4, 32'h88f46dba,
		32'h03a16125, 32'h0564f0bd, 32'hc3eb9e15, 32'h3c9057a2, 32'h97271aec, 32'ha93a072a,
		32'h1b3f6d9b, 32'h1e6321f5, 32'hf59c66fb, 32'h26dcf319, 32'h7533d928, 32'hb155fdf5,
		32'h03563482, 32'h8aba3cbb, 32'h28517711, 32'hc20ad9f8, 32'habcc5167, 32'hccad925f,
		32'h4de81751, 32'h3830dc8e, 32'h379d5862, 32'h9320f991, 32'hea7a90c2, 32'hfb3e7bce,
		32'h5121ce64, 32'h774fbe32, 32'ha8b6e37e, 32'hc3293d46, 32'h48de5369, 32'h6413e680,
		32'ha2ae0810, 32'hdd6db224, 32'h69852dfd, 32'h09072166, 32'hb39a460a, 32'h6445c0dd,
		32'h586cdecf, 32'h1c20c8ae, 32'h5bbef7dd, 32'h1b588d40, 32'hccd2017f, 32'h6bb4e3bb,
		32'hdda26a7e, 32'h3a59ff45, 32'h3e350a44, 32'hbcb4cdd5, 32'h72eacea8, 32'hfa6484bb,
		32'h8d6612ae, 32'hbf3c6f47, 32'hd29be463, 32'h542f5d9e, 32'haec2771b, 32'hf64e6370,
		32'h740e0d8d, 32'he75b1357, 32'hf8721671, 32'haf537d5d, 32'h4040cb08, 32'h4eb4e2cc,
		32'h34d2466a, 32'h0115af84, 32'he1b00428, 32'h95983a1d, 32'h06b89fb4, 32'hce6ea048,
		32'h6f3f3b82, 32'h3520ab82, 32'h011a1d4b, 32'h277227f8, 32'h611560b1, 32'he7933fdc,
		32'hbb3a792b, 32'h344525bd, 32'ha08839e1, 32'h51ce794b, 32'h2f32c9b7, 32'ha01fbac9,
		32'he01cc87e, 32'hbcc7d1f6, 32'hcf0111c3, 32'ha1e8aac7, 32'h1a908749, 32'hd44fbd9a,
		32'hd0dadecb, 32'hd50ada38, 32'h0339c32a, 32'hc6913667, 32'h8df9317c, 32'he0b12b4f,
		32'hf79e59b7, 32'h43f5bb3a, 32'hf2d519ff, 32'h27d9459c, 32'hbf97222c, 32'h15e6fc2a,
		32'h0f91fc71, 32'h9b941525, 32'hfae59361, 32'hceb69ceb, 32'hc2a86459, 32'h12baa8d1,
		32'hb6c1075e, 32'he3056a0c, 32'h10d25065, 32'hcb03a442, 32'he0ec6e0e, 32'h1698db3b,
		32'h4c98a0be, 32'h3278e964, 32'h9f1f9532, 32'he0d392df, 32'hd3a0342b, 32'h8971f21e,
		32'h1b0a7441, 32'h4ba3348c, 32'hc5be7120, 32'hc37632d8, 32'hdf359f8d, 32'h9b992f2e,
		32'he60b6f47, 32'h0fe3f11d, 32'he54cda54, 32'h1edad891, 32'hce6279cf, 32'hcd3e7e6f,
		32'h1618b166, 32'hfd2c1d05, 32'h848fd2c5, 32'hf6fb2299, 32'hf523f357, 32'ha6327623,
		32'h93a83531, 32'h56cccd02, 32'hacf08162, 32'h5a75ebb5, 32'h6e163697, 32'h88d273cc,
		32'hde966292, 32'h81b949d0, 32'h4c50901b, 32'h71c65614, 32'he6c6c7bd, 32'h327a140a,
		32'h45e1d006, 32'hc3f27b9a, 32'hc9aa53fd, 32'h62a80f00, 32'hbb25bfe2, 32'h35bdd2f6,
		32'h71126905, 32'hb2040222, 32'hb6cbcf7c, 32'hcd769c2b, 32'h53113ec0, 32'h1640e3d3,
		32'h38abbd60, 32'h2547adf0, 32'hba38209c, 32'hf746ce76, 32'h77afa1c5, 32'h20756060,
		32'h85cbfe4e, 32'h8ae88dd8, 32'h7aaaf9b0, 32'h4cf9aa7e, 32'h1948c25c, 32'h02fb8a8c,
		32'h01c36ae4, 32'hd6ebe1f9, 32'h90d4f869, 32'ha65cdea0, 32'h3f09252d, 32'hc208e69f,
		32'hb74e6132, 32'hce77e25b, 32'h578fdfe3, 32'h3ac372e6
		}
	};

endpackage

// ===== rtl/blowfish_block_cipher.sv =====
// Top level of the 16-round Blowfish engine: control, subkeys and S-box banks.
//
// Encrypt and decrypt run from the accepting edge to the done strobe: a
// whitening state issues the first S-box reads, then the round state runs the
// rounds, each round's four S-box reads coming back from the banked RAM and
// feeding the next round's addresses directly. The done strobe falls in
// the cycle where busy drops, so a new item can be started at that edge.
// Encrypt or decrypt while unkeyed, and operation 3, answer in the cycle after they are accepted.
// Expand loads the initial S-boxes (folding the key into the subkeys as it
// goes), then runs 521 chained block encryptions, with an extra write state
// for each of the 512 S-box pairs, then the duplicate scan, which compares
// every pair within each box (all four boxes in parallel). Results are held
// for exactly one cycle by done; the receiver cannot stall the block.
module blowfish_block_cipher (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [1:0]  operation,
	input  logic [31:0] in_left,
	input  logic [31:0] in_right,
	output logic        done,
	output logic [31:0] out_left,
	output logic [31:0] out_right,
	output logic [1:0]  status,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [2:0]  cfg_index,
	input  logic [63:0] cfg_data
);
	import bf_pkg::*;

	localparam int SB_AW = $clog2(SBOX_DEPTH);

	fsm_t state_q, state_d;

	logic [63:0] key_q [KEY_WORDS];
	logic [5:0]  key_bytes_q;
	logic        keyed_q;
	logic        done_q;

	logic [31:0] p_q [SUBKEYS];
	logic        dec_q, exp_q, weak_q, first_q;
	logic [31:0] l_q, r_q, a_q, b_q;
	logic [3:0]  rnd_q;
	logic [7:0]  cnt_q;
	logic [5:0]  j_q;
	logic [23:0] d_q;
	logic [9:0]  blk_q;
	logic [7:0]  i_q, k_q;
	logic [31:0] hold_q [NUM_SBOX];
	logic [31:0] out_l_q, out_r_q;
	status_t     status_q;

	logic             ram_we    [NUM_SBOX];
	logic [SB_AW-1:0] ram_waddr [NUM_SBOX];
	logic [31:0]      ram_wdata [NUM_SBOX];
	logic [SB_AW-1:0] ram_raddr [NUM_SBOX];
	logic [31:0]      ram_rdata [NUM_SBOX];

	logic        accept;
	op_t         op;
	logic [31:0] f, nb, a_next, p_start, res_l, res_r;
	logic [4:0]  kn;
	logic        last_rnd;
	logic [5:0]  len_eff;
	logic [7:0]  kbyte;
	logic [8:0]  sidx;
	logic        hit, weak_final, sched_p, ck_end;

	assign op       = op_t'(operation);
	assign accept   = start && (state_q == ST_IDLE);
	assign busy     = (state_q != ST_IDLE);
	assign cfg_ready = 1'b1;

	assign len_eff = (key_bytes_q == 6'd0) ? 6'd1 :
		((key_bytes_q > 6'(MAX_KEY_BYTES)) ? 6'(MAX_KEY_BYTES) : key_bytes_q);
	assign kbyte = 8'(key_q[j_q[5:3]] >> {~j_q[2:0], 3'b000});

	// round datapath
	assign p_start  = dec_q ? p_q[SUBKEYS-1] : p_q[0];
	assign kn       = dec_q ? 5'(5'(ROUNDS) - {1'b0, rnd_q}) : 5'({1'b0, rnd_q} + 5'd1);
	assign nb       = b_q ^ f;
	assign a_next   = (state_q == ST_CSTART) ? (l_q ^ p_start) : (nb ^ p_q[kn]);
	assign last_rnd = (rnd_q == 4'(ROUNDS - 1));
	assign res_l    = a_q ^ (dec_q ? p_q[0] : p_q[SUBKEYS-1]);
	assign res_r    = nb ^ (dec_q ? p_q[1] : p_q[SUBKEYS-2]);

	// schedule block index: first the subkey pairs, then S-box word pairs
	assign sched_p = (blk_q < 10'(SUBKEYS / 2));
	assign sidx    = 9'(blk_q - 10'(SUBKEYS / 2));

	assign hit = (ram_rdata[0] == hold_q[0]) || (ram_rdata[1] == hold_q[1]) ||
		(ram_rdata[2] == hold_q[2]) || (ram_rdata[3] == hold_q[3]);
	assign weak_final = weak_q || hit;
	assign ck_end     = (state_q == ST_CKLAST) && (i_q == 8'(SBOX_DEPTH - 2));

	bf_mix u_mix (
		.s0 (ram_rdata[0]),
		.s1 (ram_rdata[1]),
		.s2 (ram_rdata[2]),
		.s3 (ram_rdata[3]),
		.f  (f)
	);

	for (genvar b = 0; b < NUM_SBOX; b++) begin : g_bank
		bf_ram #(
			.WIDTH (32),
			.DEPTH (SBOX_DEPTH)
		) u_ram (
			.clk   (clk),
			.we    (ram_we[b]),
			.waddr (ram_waddr[b]),
			.wdata (ram_wdata[b]),
			.raddr (ram_raddr[b]),
			.rdata (ram_rdata[b])
		);

		always_comb begin
			ram_we[b]    = 1'b0;
			ram_waddr[b] = {sidx[6:0], 1'b0};
			ram_wdata[b] = res_l;
			ram_raddr[b] = a_next[31-8*b -: 8];
			case (state_q)
				ST_INIT: begin
					ram_we[b]    = 1'b1;
					ram_waddr[b] = cnt_q;
					ram_wdata[b] = PI_S[b][cnt_q];
				end
				ST_CRUN: begin
					ram_we[b] = last_rnd && exp_q && !sched_p && (sidx[8:7] == 2'(b));
				end
				ST_WRR: begin
					ram_we[b]    = (sidx[8:7] == 2'(b));
					ram_waddr[b] = {sidx[6:0], 1'b1};
					ram_wdata[b] = r_q;
				end
				ST_CKLD: begin
					ram_raddr[b] = i_q;
				end
				ST_CKSCAN: begin
					ram_raddr[b] = k_q;
				end
				default: begin
				end
			endcase
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					case (op)
						OP_ENC, OP_DEC: state_d = keyed_q ? ST_CSTART : ST_IDLE;
						OP_EXPAND:      state_d = ST_INIT;
						default:        state_d = ST_IDLE;
					endcase
				end
			end
			ST_INIT: begin
				if (cnt_q == 8'(SBOX_DEPTH - 1)) state_d = ST_CSTART;
			end
			ST_CSTART: state_d = ST_CRUN;
			ST_CRUN: begin
				if (last_rnd) begin
					if (!exp_q) state_d = ST_IDLE;
					else if (sched_p) state_d = ST_CSTART;
					else state_d = ST_WRR;
				end
			end
			ST_WRR: begin
				state_d = (blk_q == 10'(SCHED_BLOCKS - 1)) ? ST_CKLD : ST_CSTART;
			end
			ST_CKLD: state_d = ST_CKSCAN;
			ST_CKSCAN: begin
				if (k_q == 8'(SBOX_DEPTH - 1)) state_d = ST_CKLAST;
			end
			ST_CKLAST: state_d = ck_end ? ST_IDLE : ST_CKLD;
			default: state_d = ST_IDLE;
		endcase
	end

	// control state and configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			keyed_q     <= 1'b0;
			done_q      <= 1'b0;
			key_bytes_q <= 6'd8;
			for (int w = 0; w < KEY_WORDS; w++) begin
				key_q[w] <= '0;
			end
		end else begin
			state_q <= state_d;
			done_q  <= (accept && (op == OP_NOP ||
				((op == OP_ENC || op == OP_DEC) && !keyed_q))) ||
				((state_q == ST_CRUN) && last_rnd && !exp_q) || ck_end;
			if (ck_end) begin
				keyed_q <= !weak_final;
			end
			if (cfg_valid) begin
				if (cfg_index == CFG_KEY_BYTES) begin
					key_bytes_q <= cfg_data[5:0];
				end else begin
					key_q[cfg_index] <= cfg_data;
				end
			end
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					l_q      <= in_left;
					r_q      <= in_right;
					dec_q    <= (op == OP_DEC);
					exp_q    <= (op == OP_EXPAND);
					cnt_q    <= '0;
					j_q      <= '0;
					out_l_q  <= '0;
					out_r_q  <= '0;
					status_q <= ((op == OP_ENC || op == OP_DEC) && !keyed_q) ?
						STAT_NOT_KEYED : STAT_OK;
				end
			end
			ST_INIT: begin
				cnt_q <= cnt_q + 8'd1;
				if (cnt_q < 8'(4 * SUBKEYS)) begin
					// one key byte per cycle, four per subkey
					d_q <= {d_q[15:0], kbyte};
					j_q <= (j_q + 6'd1 >= len_eff) ? 6'd0 : j_q + 6'd1;
					if (cnt_q[1:0] == 2'b11) begin
						p_q[cnt_q[6:2]] <= PI_P[cnt_q[6:2]] ^ {d_q, kbyte};
					end
				end
				l_q   <= '0;
				r_q   <= '0;
				blk_q <= '0;
			end
			ST_CSTART: begin
				a_q   <= a_next;
				b_q   <= r_q;
				rnd_q <= '0;
			end
			ST_CRUN: begin
				if (!last_rnd) begin
					a_q   <= a_next;
					b_q   <= a_q;
					rnd_q <= rnd_q + 4'd1;
				end else if (!exp_q) begin
					out_l_q  <= res_l;
					out_r_q  <= res_r;
					status_q <= STAT_OK;
				end else begin
					l_q <= res_l;
					r_q <= res_r;
					if (sched_p) begin
						p_q[{blk_q[3:0], 1'b0}] <= res_l;
						p_q[{blk_q[3:0], 1'b1}] <= res_r;
						blk_q <= blk_q + 10'd1;
					end
				end
			end
			ST_WRR: begin
				blk_q  <= blk_q + 10'd1;
				i_q    <= '0;
				weak_q <= 1'b0;
			end
			ST_CKLD: begin
				k_q     <= i_q + 8'd1;
				first_q <= 1'b1;
			end
			ST_CKSCAN: begin
				k_q <= k_q + 8'd1;
				if (first_q) begin
					first_q <= 1'b0;
					for (int b = 0; b < NUM_SBOX; b++) begin
						hold_q[b] <= ram_rdata[b];
					end
				end else if (hit) begin
					weak_q <= 1'b1;
				end
			end
			ST_CKLAST: begin
				weak_q <= weak_final;
				i_q    <= i_q + 8'd1;
				if (ck_end) begin
					out_l_q  <= '0;
					out_r_q  <= '0;
					status_q <= weak_final ? STAT_WEAK : STAT_OK;
				end
			end
			default: begin
			end
		endcase
	end

	assign done      = done_q;
	assign out_left  = out_l_q;
	assign out_right = out_r_q;
	assign status    = status_q;
endmodule

// ===== rtl/bf_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module bf_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

// ===== rtl/bf_mix.sv =====
// Blowfish F function over the four S-box words of one round.
module bf_mix (
	input  logic [31:0] s0,
	input  logic [31:0] s1,
	input  logic [31:0] s2,
	input  logic [31:0] s3,
	output logic [31:0] f
);
	assign f = ((s0 + s1) ^ s2) + s3;
endmodule
